@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, muted while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, muted while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that is checked through reset as well.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ design/ccsc_pkg.sv @@
// ---------------------------------------------------------------------------
// ccsc_pkg
// Shared types and constants of the coin credit session controller.
// ---------------------------------------------------------------------------
`default_nettype none

package ccsc_pkg;

  localparam int KEY_COUNT    = 10;
  localparam int TIME_BITS    = 32;
  localparam int WAIT_BITS    = 8;
  localparam int CREDIT_BITS  = 16;
  localparam int COUNT_BITS   = 16;
  localparam int MS_PER_MINUTE = 60000;
  localparam int IDLE_MIN_BITS = 5;
  localparam int IDLE_MAX_MINUTES = (1 << IDLE_MIN_BITS) - 1;
  localparam int IDLE_LIMIT_BITS = $clog2(IDLE_MAX_MINUTES * MS_PER_MINUTE + 1);

  localparam logic [CREDIT_BITS-1:0] CREDIT_MAX = {CREDIT_BITS{1'b1}};

  // Key positions
  localparam int KEY_ACCEPTOR  = 0;
  localparam int KEY_START_ONE = 1;
  localparam int KEY_TRIG_ONE  = 2;
  localparam int KEY_RELOAD_ONE = 3;
  localparam int KEY_START_TWO = 4;
  localparam int KEY_TRIG_TWO  = 5;
  localparam int KEY_RELOAD_TWO = 6;

  // Reset values of the configuration registers
  localparam logic                     COIN_POL_RESET     = 1'b0;
  localparam logic [IDLE_MIN_BITS-1:0] IDLE_MINUTES_RESET = 5'd5;
  localparam logic [WAIT_BITS-1:0]     NORMAL_WAIT_RESET  = 8'd18;
  localparam logic [WAIT_BITS-1:0]     TRIGGER_WAIT_RESET = 8'd8;

  typedef enum logic [1:0] {
    KIND_SAMPLE  = 2'd0,
    KIND_OFF_ONE = 2'd1,
    KIND_OFF_TWO = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    REG_COIN_POLARITY = 2'd0,
    REG_IDLE_MINUTES  = 2'd1,
    REG_NORMAL_WAIT   = 2'd2,
    REG_TRIGGER_WAIT  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [KEY_COUNT-1:0] states;
    logic [KEY_COUNT-1:0] changes;
  } key_report_t;

  typedef struct packed {
    logic [CREDIT_BITS-1:0] credits;
    logic [1:0]             active;
  } session_report_t;

  function automatic logic [IDLE_LIMIT_BITS-1:0] idle_limit_of(
    input logic [IDLE_MIN_BITS-1:0] minutes
  );
    logic [IDLE_LIMIT_BITS-1:0] prod;
    prod = IDLE_LIMIT_BITS'(minutes) * IDLE_LIMIT_BITS'(MS_PER_MINUTE);
    return prod;
  endfunction

endpackage

`default_nettype wire

@@ design/ccsc_debounce.sv @@
// ---------------------------------------------------------------------------
// ccsc_debounce
// Ten parallel key debouncers timed by the sample timestamps.
// ---------------------------------------------------------------------------
`default_nettype none

module ccsc_debounce (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                step,
  input  wire logic                                sample,
  input  wire logic [ccsc_pkg::KEY_COUNT-1:0]      active,
  input  wire logic [ccsc_pkg::TIME_BITS-1:0]      now,
  input  wire logic [ccsc_pkg::WAIT_BITS-1:0]      normal_wait,
  input  wire logic [ccsc_pkg::WAIT_BITS-1:0]      trigger_wait,
  output ccsc_pkg::key_report_t                    report
);

  logic [ccsc_pkg::KEY_COUNT-1:0] started;
  logic [ccsc_pkg::KEY_COUNT-1:0] raw;
  logic [ccsc_pkg::KEY_COUNT-1:0] stable;
  logic [ccsc_pkg::KEY_COUNT-1:0] stable_next;
  logic [ccsc_pkg::TIME_BITS-1:0] change_time      [ccsc_pkg::KEY_COUNT];
  logic [ccsc_pkg::TIME_BITS-1:0] change_time_next [ccsc_pkg::KEY_COUNT];
  logic [ccsc_pkg::TIME_BITS-1:0] elapsed          [ccsc_pkg::KEY_COUNT];
  logic [ccsc_pkg::WAIT_BITS-1:0] wait_ms          [ccsc_pkg::KEY_COUNT];

  always_comb begin
    for (int i = 0; i < ccsc_pkg::KEY_COUNT; i++) begin
      wait_ms[i] = (i == ccsc_pkg::KEY_TRIG_ONE || i == ccsc_pkg::KEY_TRIG_TWO) ?
                   trigger_wait : normal_wait;
      // restart the timer on the first sample or whenever the raw level moves
      change_time_next[i] = (!started[i] || (raw[i] != active[i])) ? now : change_time[i];
      elapsed[i] = now - change_time_next[i];
      if (!started[i]) begin
        stable_next[i] = active[i];
      end else if (elapsed[i] >= ccsc_pkg::TIME_BITS'(wait_ms[i])) begin
        stable_next[i] = active[i];
      end else begin
        stable_next[i] = stable[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= '0;
      raw     <= '0;
      stable  <= '0;
    end else if (step && sample) begin
      started <= '1;
      raw     <= active;
      stable  <= stable_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && sample) begin
      for (int i = 0; i < ccsc_pkg::KEY_COUNT; i++) begin
        change_time[i] <= change_time_next[i];
      end
    end
  end

  assign report.states  = sample ? stable_next : stable;
  assign report.changes = sample ? (stable_next ^ stable) : '0;

endmodule

`default_nettype wire

@@ design/ccsc_session.sv @@
// ---------------------------------------------------------------------------
// ccsc_session
// Credit counter, player sessions and idle timeouts.
// ---------------------------------------------------------------------------
`default_nettype none

module ccsc_session (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  step,
  input  wire logic [1:0]                            kind,
  input  wire logic [ccsc_pkg::TIME_BITS-1:0]        now,
  input  wire logic [ccsc_pkg::KEY_COUNT-1:0]        keys,
  input  wire logic [ccsc_pkg::IDLE_LIMIT_BITS-1:0]  idle_limit,
  output ccsc_pkg::session_report_t                  report
);

  logic [2:0]                         prev_edge;
  logic [2:0]                         prev_edge_next;
  logic [ccsc_pkg::CREDIT_BITS-1:0]   credits;
  logic [ccsc_pkg::CREDIT_BITS-1:0]   credits_next;
  logic [1:0]                         active;
  logic [1:0]                         active_next;
  logic [ccsc_pkg::TIME_BITS-1:0]     last_time      [2];
  logic [ccsc_pkg::TIME_BITS-1:0]     last_time_next [2];
  logic [ccsc_pkg::TIME_BITS-1:0]     idle_for       [2];
  logic                               coin;
  logic                               start_one;
  logic                               start_two;

  assign coin      = keys[ccsc_pkg::KEY_ACCEPTOR];
  assign start_one = keys[ccsc_pkg::KEY_START_ONE];
  assign start_two = keys[ccsc_pkg::KEY_START_TWO];

  always_comb begin
    prev_edge_next    = prev_edge;
    credits_next      = credits;
    active_next       = active;
    last_time_next[0] = last_time[0];
    last_time_next[1] = last_time[1];
    idle_for[0]       = '0;
    idle_for[1]       = '0;
    unique case (kind)
      ccsc_pkg::KIND_SAMPLE: begin
        if (coin && !prev_edge[0] && credits_next != ccsc_pkg::CREDIT_MAX) begin
          credits_next = credits_next + 1'b1;
        end
        // player one is served before player two
        if (start_one && !prev_edge[1] && !active_next[0] && credits_next != '0) begin
          credits_next      = credits_next - 1'b1;
          active_next[0]    = 1'b1;
          last_time_next[0] = now;
        end
        if (start_two && !prev_edge[2] && !active_next[1] && credits_next != '0) begin
          credits_next      = credits_next - 1'b1;
          active_next[1]    = 1'b1;
          last_time_next[1] = now;
        end
        prev_edge_next = {start_two, start_one, coin};
        if (active_next[0] && (keys[ccsc_pkg::KEY_TRIG_ONE] ||
                               keys[ccsc_pkg::KEY_RELOAD_ONE])) begin
          last_time_next[0] = now;
        end
        if (active_next[1] && (keys[ccsc_pkg::KEY_TRIG_TWO] ||
                               keys[ccsc_pkg::KEY_RELOAD_TWO])) begin
          last_time_next[1] = now;
        end
        idle_for[0] = now - last_time_next[0];
        idle_for[1] = now - last_time_next[1];
        if (idle_limit != '0) begin
          if (idle_for[0] > ccsc_pkg::TIME_BITS'(idle_limit)) begin
            active_next[0] = 1'b0;
          end
          if (idle_for[1] > ccsc_pkg::TIME_BITS'(idle_limit)) begin
            active_next[1] = 1'b0;
          end
        end
      end
      ccsc_pkg::KIND_OFF_ONE: active_next[0] = 1'b0;
      ccsc_pkg::KIND_OFF_TWO: active_next[1] = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_edge    <= '0;
      credits      <= '0;
      active       <= '0;
      last_time[0] <= '0;
      last_time[1] <= '0;
    end else if (step) begin
      prev_edge    <= prev_edge_next;
      credits      <= credits_next;
      active       <= active_next;
      last_time[0] <= last_time_next[0];
      last_time[1] <= last_time_next[1];
    end
  end

  assign report.credits = credits_next;
  assign report.active  = active_next;

endmodule

`default_nettype wire

@@ design/coin_credit_session_controller.sv @@
// ---------------------------------------------------------------------------
// coin_credit_session_controller
// Debounces ten arcade keys, counts coin credits and runs two player sessions.
// ---------------------------------------------------------------------------
//  channel  | direction | payload
//  ---------+-----------+----------------------------------------------------
//  s_*      | in        | tuser: kind; tdata: timestamp_ms, pin_levels
//  m_*      | out       | tdata: key states/changes, credits, actives, relays
//  cfg_*    | in        | cfg_index selects register, cfg_data carries value
//
//  Each item passes through the input register and then the result
//  register; one item per cycle is sustained while m_tready stays high.
//  All state (debouncers, credits, sessions) updates in the single step from
//  the input register to the result register.
//  A stall on m_tready fills the input register, then drops s_tready.
//  Reset clears all state and loads the default configuration.
// ---------------------------------------------------------------------------
`default_nettype none

module coin_credit_session_controller (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // [31:0] timestamp_ms, [41:32] pin_levels, zero pad
  input  wire logic [1:0]  s_tuser,   // [1:0] kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [9:0] key_states, [19:10] key_changes,
                                      // [35:20] credit_count, [36] player_one_active,
                                      // [37] player_two_active, [38] relay_one_level,
                                      // [39] relay_two_level
  input  wire logic        cfg_wvalid,
  output logic             cfg_wready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  logic                                    coin_pol;
  logic [ccsc_pkg::IDLE_LIMIT_BITS-1:0]    idle_limit;
  logic [ccsc_pkg::WAIT_BITS-1:0]          normal_wait;
  logic [ccsc_pkg::WAIT_BITS-1:0]          trigger_wait;

  logic                                    s1_valid;
  logic [1:0]                              s1_kind;
  logic [ccsc_pkg::TIME_BITS-1:0]          s1_time;
  logic [ccsc_pkg::KEY_COUNT-1:0]          s1_pins;
  logic                                    s1_advance;
  logic                                    s1_sample;
  logic [ccsc_pkg::KEY_COUNT-1:0]          key_active;

  ccsc_pkg::key_report_t                   keys;
  ccsc_pkg::session_report_t               sess;
  logic                                    relay_one;
  logic                                    relay_two;

  assign cfg_wready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coin_pol     <= ccsc_pkg::COIN_POL_RESET;
      idle_limit   <= ccsc_pkg::idle_limit_of(ccsc_pkg::IDLE_MINUTES_RESET);
      normal_wait  <= ccsc_pkg::NORMAL_WAIT_RESET;
      trigger_wait <= ccsc_pkg::TRIGGER_WAIT_RESET;
    end else if (cfg_wvalid && cfg_wready) begin
      unique case (cfg_index)
        ccsc_pkg::REG_COIN_POLARITY: coin_pol     <= cfg_data[0];
        ccsc_pkg::REG_IDLE_MINUTES:  idle_limit   <=
          ccsc_pkg::idle_limit_of(cfg_data[ccsc_pkg::IDLE_MIN_BITS-1:0]);
        ccsc_pkg::REG_NORMAL_WAIT:   normal_wait  <= cfg_data;
        ccsc_pkg::REG_TRIGGER_WAIT:  trigger_wait <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register advances whenever the result register is free or draining
  assign s1_advance = s1_valid && (!m_tvalid || m_tready);
  assign s_tready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_kind <= s_tuser;
      s1_time <= s_tdata[31:0];
      s1_pins <= s_tdata[41:32];
    end
  end

  assign s1_sample = (s1_kind == ccsc_pkg::KIND_SAMPLE);

  // coin follows the polarity register, every other key is active low
  always_comb begin
    key_active = ~s1_pins;
    key_active[ccsc_pkg::KEY_ACCEPTOR] = s1_pins[ccsc_pkg::KEY_ACCEPTOR] ~^ coin_pol;
  end

  ccsc_debounce u_debounce (
    .clk          (clk),
    .rst          (rst),
    .step         (s1_advance),
    .sample       (s1_sample),
    .active       (key_active),
    .now          (s1_time),
    .normal_wait  (normal_wait),
    .trigger_wait (trigger_wait),
    .report       (keys)
  );

  ccsc_session u_session (
    .clk        (clk),
    .rst        (rst),
    .step       (s1_advance),
    .kind       (s1_kind),
    .now        (s1_time),
    .keys       (keys.states),
    .idle_limit (idle_limit),
    .report     (sess)
  );

  assign relay_one = ~((sess.active[0] & keys.states[ccsc_pkg::KEY_TRIG_ONE]) ^ coin_pol);
  assign relay_two = ~((sess.active[1] & keys.states[ccsc_pkg::KEY_TRIG_TWO]) ^ coin_pol);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      m_tdata <= {relay_two, relay_one, sess.active[1], sess.active[0],
                  ccsc_pkg::COUNT_BITS'(sess.credits), keys.changes, keys.states};
    end
  end

endmodule

`default_nettype wire

@@ design/ccsc_checker.sv @@
// ---------------------------------------------------------------------------
// ccsc_checker
// Port-level checks on the coin credit session controller.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ccsc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata
);

  // a held result keeps its payload until the transfer
  `ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // reset empties the result register
  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !m_tvalid)

  // with no result pending the input side is always open
  `ASSERT_IMPLIES(a_ready_when_empty, clk, rst, !m_tvalid, s_tready)

  // with no active player both relays sit at the same off level
  `ASSERT_IMPLIES(a_relays_off, clk, rst, m_tvalid && !m_tdata[36] && !m_tdata[37],
                  m_tdata[38] == m_tdata[39])

endmodule

bind coin_credit_session_controller ccsc_checker u_ccsc_checker (.*);

`default_nettype wire
